@@ hw/rtl/gaussian_blur_rgb_macros.svh @@
// Assertion macros shared by the blur block; compiled out for synthesis.
`ifndef GAUSSIAN_BLUR_RGB_MACROS_SVH
`define GAUSSIAN_BLUR_RGB_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk and disabled during reset.
`define GBR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gaussian_blur_rgb: same-cycle check failed");
// Next-cycle implication, clocked on clk and disabled during reset.
`define GBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gaussian_blur_rgb: next-cycle check failed");
`else
`define GBR_ASSERT_NOW(lbl, ante, cons)
`define GBR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/gbr_pkg.sv @@
// Shared constants, weight table and types of the Gaussian blur block.
`timescale 1ns / 1ps
package gbr_pkg;

  // Frame geometry and window size.
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int RADIUS     = 10;
  localparam int TAPS       = 2 * RADIUS + 1;
  localparam int TAPS_MAX   = 16;

  localparam int POS_W   = 7;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int OFF_W   = $clog2(TAPS);
  localparam int IDX_W   = $clog2(TAPS_MAX);

  // Arithmetic widths: Q0.16 taps, Q0.32 2-D weights, 8-bit samples.
  localparam int FRAC_W  = 16;
  localparam int WGT_W   = FRAC_W + 1;
  localparam int WPROD_W = 2 * FRAC_W + 1;
  localparam int ACC_W   = WPROD_W + CHAN_W;

  // Stream and register port widths.
  localparam int IN_DATA_W  = ((2 * POS_W + PIX_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((PIX_W + 2 * POS_W + 7) / 8) * 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_W      = 8;

  // Register indexes and reset values.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;
  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = REG_W'(128);
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = REG_W'(128);

  // Item kinds carried on tuser.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  // exp(-k*k/200) in Q0.16, rounded.
  localparam longint unsigned ONE_Q16 = 64'd65536;
  localparam longint unsigned GAUSS_RAW [TAPS_MAX] = '{
    64'd65536, 64'd65209, 64'd64238, 64'd62652, 64'd60497, 64'd57835, 64'd54740, 64'd51295,
    64'd47589, 64'd43711, 64'd39750, 64'd35788, 64'd31900, 64'd28151, 64'd24596, 64'd21276
  };

  // Sum of the raw kernel across the whole window.
  function automatic longint unsigned gauss_sum();
    longint unsigned s;
    s = GAUSS_RAW[0];
    for (int k = 1; k <= RADIUS; k++) begin
      s = s + 2 * GAUSS_RAW[k];
    end
    return s;
  endfunction

  localparam longint unsigned GSUM = gauss_sum();
  localparam longint unsigned GHALF = GSUM / 2;

  // Normalized side taps, rounded to nearest.
  localparam longint unsigned WS1  = (RADIUS >= 1)  ? (GAUSS_RAW[1]  * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS2  = (RADIUS >= 2)  ? (GAUSS_RAW[2]  * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS3  = (RADIUS >= 3)  ? (GAUSS_RAW[3]  * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS4  = (RADIUS >= 4)  ? (GAUSS_RAW[4]  * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS5  = (RADIUS >= 5)  ? (GAUSS_RAW[5]  * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS6  = (RADIUS >= 6)  ? (GAUSS_RAW[6]  * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS7  = (RADIUS >= 7)  ? (GAUSS_RAW[7]  * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS8  = (RADIUS >= 8)  ? (GAUSS_RAW[8]  * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS9  = (RADIUS >= 9)  ? (GAUSS_RAW[9]  * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS10 = (RADIUS >= 10) ? (GAUSS_RAW[10] * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS11 = (RADIUS >= 11) ? (GAUSS_RAW[11] * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS12 = (RADIUS >= 12) ? (GAUSS_RAW[12] * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS13 = (RADIUS >= 13) ? (GAUSS_RAW[13] * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS14 = (RADIUS >= 14) ? (GAUSS_RAW[14] * ONE_Q16 + GHALF) / GSUM : 0;
  localparam longint unsigned WS15 = (RADIUS >= 15) ? (GAUSS_RAW[15] * ONE_Q16 + GHALF) / GSUM : 0;

  // The center tap takes up the rounding so the taps sum to exactly one.
  localparam longint unsigned WS0 = ONE_Q16 - 2 * (WS1 + WS2 + WS3 + WS4 + WS5 + WS6 + WS7 +
                                    WS8 + WS9 + WS10 + WS11 + WS12 + WS13 + WS14 + WS15);

  localparam logic [WGT_W-1:0] WEIGHT [TAPS_MAX] = '{
    WGT_W'(WS0),  WGT_W'(WS1),  WGT_W'(WS2),  WGT_W'(WS3),
    WGT_W'(WS4),  WGT_W'(WS5),  WGT_W'(WS6),  WGT_W'(WS7),
    WGT_W'(WS8),  WGT_W'(WS9),  WGT_W'(WS10), WGT_W'(WS11),
    WGT_W'(WS12), WGT_W'(WS13), WGT_W'(WS14), WGT_W'(WS15)
  };

  // Control that travels with each window tap down the datapath.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tap_ctl_t;

endpackage

@@ hw/rtl/gbr_frame_store.sv @@
// Frame store: one write port and one registered read port.
`timescale 1ns / 1ps
module gbr_frame_store (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [gbr_pkg::ADDR_W-1:0]     wr_addr,
  input  logic [gbr_pkg::PIX_W-1:0]      wr_data,
  input  logic                           rd_en,
  input  logic [gbr_pkg::ADDR_W-1:0]     rd_addr,
  output logic [gbr_pkg::PIX_W-1:0]      rd_data
);

  logic [gbr_pkg::PIX_W-1:0] mem [gbr_pkg::DEPTH];
  logic [gbr_pkg::PIX_W-1:0] rd_data_r;

  // No reset; user must read only written pixels; not enforced.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/gbr_tap_seq.sv @@
// Window sequencer: walks the taps, clamps coordinates and forms 2-D weights.
`timescale 1ns / 1ps
module gbr_tap_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gbr_pkg::COL_W-1:0]     pos_x,
  input  logic [gbr_pkg::ROW_W-1:0]     pos_y,
  input  logic [gbr_pkg::COL_W-1:0]     last_x,
  input  logic [gbr_pkg::ROW_W-1:0]     last_y,
  output logic                          busy,
  output logic                          rd_en,
  output logic [gbr_pkg::ADDR_W-1:0]    rd_addr,
  output gbr_pkg::tap_ctl_t             tap,
  output logic [gbr_pkg::WPROD_W-1:0]   wgt
);

  localparam int XW = gbr_pkg::COL_W + 2;
  localparam int YW = gbr_pkg::ROW_W + 2;
  localparam logic [gbr_pkg::OFF_W-1:0] OFF_LAST = gbr_pkg::OFF_W'(gbr_pkg::TAPS - 1);
  localparam logic [gbr_pkg::OFF_W-1:0] OFF_MID  = gbr_pkg::OFF_W'(gbr_pkg::RADIUS);

  logic                          busy_r, busy_nxt;
  logic [gbr_pkg::OFF_W-1:0]     ox_r, ox_nxt;
  logic [gbr_pkg::OFF_W-1:0]     oy_r, oy_nxt;
  gbr_pkg::tap_ctl_t             tap_r, tap_nxt;
  logic [gbr_pkg::WPROD_W-1:0]   wgt_r;

  logic signed [XW-1:0]          cx;
  logic signed [YW-1:0]          cy;
  logic [gbr_pkg::COL_W-1:0]     ix;
  logic [gbr_pkg::ROW_W-1:0]     iy;
  logic [gbr_pkg::IDX_W-1:0]     wix, wiy;
  logic                          row_end, win_end;

  assign row_end = (ox_r == OFF_LAST);
  assign win_end = row_end && (oy_r == OFF_LAST);

  // Tap counters: column offset runs fastest.
  always_comb begin
    busy_nxt = busy_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    if (start) begin
      busy_nxt = 1'b1;
      ox_nxt   = '0;
      oy_nxt   = '0;
    end else if (busy_r) begin
      if (row_end) begin
        ox_nxt = '0;
        oy_nxt = oy_r + 1'b1;
      end else begin
        ox_nxt = ox_r + 1'b1;
      end
      if (win_end) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Clamp the tap coordinates into the active frame.
  always_comb begin
    cx = $signed(XW'(pos_x) + XW'(ox_r) - XW'(gbr_pkg::RADIUS));
    cy = $signed(YW'(pos_y) + YW'(oy_r) - YW'(gbr_pkg::RADIUS));
    if (cx < 0) begin
      ix = '0;
    end else if (cx > $signed(XW'(last_x))) begin
      ix = last_x;
    end else begin
      ix = cx[gbr_pkg::COL_W-1:0];
    end
    if (cy < 0) begin
      iy = '0;
    end else if (cy > $signed(YW'(last_y))) begin
      iy = last_y;
    end else begin
      iy = cy[gbr_pkg::ROW_W-1:0];
    end
  end

  // Distance from the center selects the one-dimensional tap.
  assign wix = (ox_r >= OFF_MID) ? gbr_pkg::IDX_W'(ox_r - OFF_MID)
                                 : gbr_pkg::IDX_W'(OFF_MID - ox_r);
  assign wiy = (oy_r >= OFF_MID) ? gbr_pkg::IDX_W'(oy_r - OFF_MID)
                                 : gbr_pkg::IDX_W'(OFF_MID - oy_r);

  assign rd_en   = busy_r;
  assign rd_addr = gbr_pkg::ADDR_W'(gbr_pkg::ADDR_W'(iy) * gbr_pkg::ADDR_W'(gbr_pkg::MAX_WIDTH)
                   + gbr_pkg::ADDR_W'(ix));

  always_comb begin
    tap_nxt.valid = busy_r;
    tap_nxt.first = busy_r && (ox_r == '0) && (oy_r == '0);
    tap_nxt.last  = busy_r && win_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tap_r  <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      tap_r  <= tap_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
    end
  end

  // The 2-D weight lines up with the pixel read from the frame store.
  always_ff @(posedge clk) begin
    wgt_r <= gbr_pkg::WPROD_W'(gbr_pkg::WEIGHT[wix]) *
             gbr_pkg::WPROD_W'(gbr_pkg::WEIGHT[wiy]);
  end

  assign busy = busy_r;
  assign tap  = tap_r;
  assign wgt  = wgt_r;

endmodule

@@ hw/rtl/gbr_mac.sv @@
// Multiply-accumulate unit shared by every tap of the window, one lane per color.
`timescale 1ns / 1ps
module gbr_mac (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gbr_pkg::tap_ctl_t              tap,
  input  logic [gbr_pkg::WPROD_W-1:0]    wgt,
  input  logic [gbr_pkg::PIX_W-1:0]      pix,
  output logic                           done,
  output logic [gbr_pkg::CHAN_W-1:0]     res_red,
  output logic [gbr_pkg::CHAN_W-1:0]     res_green,
  output logic [gbr_pkg::CHAN_W-1:0]     res_blue
);

  localparam int SHIFT = 2 * gbr_pkg::FRAC_W;

  gbr_pkg::tap_ctl_t             ctl_r;
  logic                          done_r;
  logic [gbr_pkg::ACC_W-1:0]     prod_r [3];
  logic [gbr_pkg::ACC_W-1:0]     acc_r  [3];

  // Lane 0 is red in the top byte of the pixel, lane 2 is blue.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= gbr_pkg::ACC_W'(wgt) *
                   gbr_pkg::ACC_W'(pix[(2 - c) * gbr_pkg::CHAN_W +: gbr_pkg::CHAN_W]);
    end
  end

  // The first tap of a window restarts the sums.
  always_ff @(posedge clk) begin
    if (ctl_r.valid) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= ctl_r.first ? prod_r[c] : acc_r[c] + prod_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      done_r <= 1'b0;
    end else begin
      ctl_r  <= tap;
      done_r <= ctl_r.valid && ctl_r.last;
    end
  end

  // The sums hold after the last tap until the next window starts.
  assign done      = done_r;
  assign res_red   = acc_r[0][SHIFT +: gbr_pkg::CHAN_W];
  assign res_green = acc_r[1][SHIFT +: gbr_pkg::CHAN_W];
  assign res_blue  = acc_r[2][SHIFT +: gbr_pkg::CHAN_W];

endmodule

@@ hw/rtl/gaussian_blur_rgb.sv @@
// Top level of the RGB Gaussian blur over a frame store.
`timescale 1ns / 1ps
`include "gaussian_blur_rgb_macros.svh"
// A load beat writes one pixel into the 128x128 frame store and is taken while in_tready is high.
// A compute beat blurs the pixel at (x,y) with a 21x21 separable Gaussian and clamp-to-edge
// borders: the window is walked one tap per cycle through the frame store's single read
// port and one shared multiply-accumulate unit, so a compute occupies the block for the
// whole tap walk plus the read, multiply, accumulate and hand-off steps, during which
// in_tready is low. The result sits in an output register, so the next beat is taken
// while it waits. The frame store has no reset; only loaded pixels may be read.
module gaussian_blur_rgb (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pos_x[6:0], pos_y[13:7], in_red[21:14], in_green[29:22], in_blue[37:30], zero pad
  input  logic [gbr_pkg::IN_DATA_W-1:0]       in_tdata,
  // action: 0 load, 1 compute
  input  logic                                in_tuser,
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_x[30:24], out_y[37:31], zero pad
  output logic [gbr_pkg::OUT_DATA_W-1:0]      out_tdata,
  // Register port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [gbr_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [gbr_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [gbr_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  localparam int P = gbr_pkg::POS_W;
  localparam int C = gbr_pkg::CHAN_W;

  state_t                           state_r, state_nxt;
  logic [gbr_pkg::REG_W-1:0]        frame_width_r, frame_height_r;
  logic [gbr_pkg::COL_W-1:0]        pos_x_r;
  logic [gbr_pkg::ROW_W-1:0]        pos_y_r;
  logic                             out_tvalid_r, out_tvalid_nxt;
  logic [gbr_pkg::OUT_DATA_W-1:0]   out_tdata_r;

  logic                             in_acc, cfg_wr, out_free, start, load_we;
  logic [P-1:0]                     f_pos_x, f_pos_y;
  logic [gbr_pkg::PIX_W-1:0]        f_pix;
  logic [gbr_pkg::ADDR_W-1:0]       wr_addr;
  logic [gbr_pkg::COL_W-1:0]        last_x;
  logic [gbr_pkg::ROW_W-1:0]        last_y;

  logic                             seq_busy, rd_en, mac_done;
  logic [gbr_pkg::ADDR_W-1:0]       rd_addr;
  gbr_pkg::tap_ctl_t                tap;
  logic [gbr_pkg::WPROD_W-1:0]      wgt;
  logic [gbr_pkg::PIX_W-1:0]        rd_data;
  logic [C-1:0]                     res_red, res_green, res_blue;

  // Unpack the input beat.
  assign f_pos_x = in_tdata[0 +: P];
  assign f_pos_y = in_tdata[P +: P];
  assign f_pix   = {in_tdata[2 * P +: C], in_tdata[2 * P + C +: C], in_tdata[2 * P + 2 * C +: C]};

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign start     = in_acc && (in_tuser == gbr_pkg::ACT_COMPUTE);
  assign load_we   = in_acc && (in_tuser == gbr_pkg::ACT_LOAD) &&
                     (int'(f_pos_x) < gbr_pkg::MAX_WIDTH) && (int'(f_pos_y) < gbr_pkg::MAX_HEIGHT);
  assign wr_addr   = gbr_pkg::ADDR_W'(gbr_pkg::ADDR_W'(f_pos_y) *
                     gbr_pkg::ADDR_W'(gbr_pkg::MAX_WIDTH) + gbr_pkg::ADDR_W'(f_pos_x));

  // Register port: always ready, write on the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      gbr_pkg::REG_FRAME_WIDTH:  cfg_prdata = gbr_pkg::CFG_DATA_W'(frame_width_r);
      gbr_pkg::REG_FRAME_HEIGHT: cfg_prdata = gbr_pkg::CFG_DATA_W'(frame_height_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= gbr_pkg::FRAME_WIDTH_RST;
      frame_height_r <= gbr_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == gbr_pkg::REG_FRAME_WIDTH) begin
        frame_width_r <= cfg_pwdata[gbr_pkg::REG_W-1:0];
      end else begin
        frame_height_r <= cfg_pwdata[gbr_pkg::REG_W-1:0];
      end
    end
  end

  // Last valid column and row; zero counts as one, oversize as the maximum.
  always_comb begin
    if (frame_width_r == '0) begin
      last_x = '0;
    end else if (int'(frame_width_r) > gbr_pkg::MAX_WIDTH) begin
      last_x = gbr_pkg::COL_W'(gbr_pkg::MAX_WIDTH - 1);
    end else begin
      last_x = gbr_pkg::COL_W'(frame_width_r - 1'b1);
    end
    if (frame_height_r == '0) begin
      last_y = '0;
    end else if (int'(frame_height_r) > gbr_pkg::MAX_HEIGHT) begin
      last_y = gbr_pkg::ROW_W'(gbr_pkg::MAX_HEIGHT - 1);
    end else begin
      last_y = gbr_pkg::ROW_W'(frame_height_r - 1'b1);
    end
  end

  // Capture the center of a compute beat.
  always_ff @(posedge clk) begin
    if (start) begin
      pos_x_r <= gbr_pkg::COL_W'(f_pos_x);
      pos_y_r <= gbr_pkg::ROW_W'(f_pos_y);
    end
  end

  // Control: idle, walking the window, then waiting for the output register.
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) begin
        state_nxt = ST_RUN;
      end
      ST_RUN: if (mac_done) begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (state_r == ST_WAIT && out_free) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (state_r == ST_WAIT && out_free) begin
      out_tdata_r <= gbr_pkg::OUT_DATA_W'({P'(pos_y_r), P'(pos_x_r), res_blue, res_green, res_red});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  gbr_frame_store u_store (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (wr_addr),
    .wr_data (f_pix),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gbr_tap_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .pos_x   (pos_x_r),
    .pos_y   (pos_y_r),
    .last_x  (last_x),
    .last_y  (last_y),
    .busy    (seq_busy),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .tap     (tap),
    .wgt     (wgt)
  );

  gbr_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tap       (tap),
    .wgt       (wgt),
    .pix       (rd_data),
    .done      (mac_done),
    .res_red   (res_red),
    .res_green (res_green),
    .res_blue  (res_blue)
  );

  // A compute beat starts the window walk on the next cycle.
  `GBR_ASSERT_NEXT(a_start_walks, start, seq_busy)
  // The accumulator only finishes while a window is in flight.
  `GBR_ASSERT_NOW(a_done_in_run, mac_done, state_r == ST_RUN)
  // Pixel writes never collide with a window walk.
  `GBR_ASSERT_NOW(a_no_load_busy, load_we, !seq_busy)
  // Handing off a result always shows it on the output.
  `GBR_ASSERT_NEXT(a_result_shown, (state_r == ST_WAIT) && out_free, out_tvalid)

endmodule

@@ tb/tb_gaussian_blur_rgb.sv @@
// Testbench for gaussian_blur_rgb: directed table and random load/blur traffic, scoreboarded.
`timescale 1ns / 1ps
module tb_gaussian_blur_rgb;

  localparam int MAX_DIM        = 128;
  localparam int BLUR_RADIUS    = 10;
  localparam int DRAIN_CYCLES   = 500;
  localparam int PHASES         = 10;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int TIMEOUT_NS     = 10_000_000;
  localparam int DIR_LEN        = 23;

  // Register byte addresses.
  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;

  // exp(-k*k/200) in Q0.16, rounded, for the taps of one side.
  localparam longint unsigned KERNEL_RAW [0:BLUR_RADIUS] = '{
    65536, 65209, 64238, 62652, 60497, 57835, 54740, 51295, 47589, 43711, 39750
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] x;
    logic [6:0] y;
  } blur_result_t;

  typedef enum logic [1:0] {STEP_CFG, STEP_LOAD, STEP_BLUR} step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    logic [2:0]  addr;
    logic [7:0]  value;
    logic [6:0]  x;
    logic [6:0]  y;
    logic [23:0] pix;
    logic        typed;
    logic [23:0] exp_pix;
  } dir_step_t;

  // Directed steps; typed expectations are uniform windows, which blur to themselves.
  dir_step_t directed_steps [DIR_LEN] = '{
    '{STEP_CFG,  ADDR_WIDTH,  8'd1,   7'd0,   7'd0,   24'h0,      1'b0, 24'h0},
    '{STEP_CFG,  ADDR_HEIGHT, 8'd1,   7'd0,   7'd0,   24'h0,      1'b0, 24'h0},
    '{STEP_LOAD, 3'd0,        8'd0,   7'd0,   7'd0,   24'hFFFFFF, 1'b0, 24'h0},
    '{STEP_BLUR, 3'd0,        8'd0,   7'd0,   7'd0,   24'h0,      1'b1, 24'hFFFFFF},
    '{STEP_BLUR, 3'd0,        8'd0,   7'd127, 7'd127, 24'h0,      1'b1, 24'hFFFFFF},
    '{STEP_LOAD, 3'd0,        8'd0,   7'd0,   7'd0,   24'h000000, 1'b0, 24'h0},
    '{STEP_BLUR, 3'd0,        8'd0,   7'd0,   7'd0,   24'h0,      1'b1, 24'h000000},
    '{STEP_LOAD, 3'd0,        8'd0,   7'd127, 7'd127, 24'h123456, 1'b0, 24'h0},
    '{STEP_LOAD, 3'd0,        8'd0,   7'd0,   7'd0,   24'hA55A01, 1'b0, 24'h0},
    '{STEP_BLUR, 3'd0,        8'd0,   7'd64,  7'd0,   24'h0,      1'b1, 24'hA55A01},
    '{STEP_CFG,  ADDR_WIDTH,  8'd0,   7'd0,   7'd0,   24'h0,      1'b0, 24'h0},
    '{STEP_CFG,  ADDR_HEIGHT, 8'd0,   7'd0,   7'd0,   24'h0,      1'b0, 24'h0},
    '{STEP_BLUR, 3'd0,        8'd0,   7'd127, 7'd127, 24'h0,      1'b1, 24'hA55A01},
    '{STEP_LOAD, 3'd0,        8'd0,   7'd1,   7'd0,   24'hFF00FF, 1'b0, 24'h0},
    '{STEP_LOAD, 3'd0,        8'd0,   7'd0,   7'd1,   24'h00FF00, 1'b0, 24'h0},
    '{STEP_LOAD, 3'd0,        8'd0,   7'd1,   7'd1,   24'h0F0F0F, 1'b0, 24'h0},
    '{STEP_CFG,  ADDR_WIDTH,  8'd2,   7'd0,   7'd0,   24'h0,      1'b0, 24'h0},
    '{STEP_CFG,  ADDR_HEIGHT, 8'd2,   7'd0,   7'd0,   24'h0,      1'b0, 24'h0},
    '{STEP_BLUR, 3'd0,        8'd0,   7'd0,   7'd0,   24'h0,      1'b0, 24'h0},
    '{STEP_BLUR, 3'd0,        8'd0,   7'd1,   7'd1,   24'h0,      1'b0, 24'h0},
    '{STEP_BLUR, 3'd0,        8'd0,   7'd100, 7'd3,   24'h0,      1'b0, 24'h0},
    '{STEP_CFG,  ADDR_WIDTH,  8'd255, 7'd0,   7'd0,   24'h0,      1'b0, 24'h0},
    '{STEP_CFG,  ADDR_HEIGHT, 8'd255, 7'd0,   7'd0,   24'h0,      1'b0, 24'h0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [gbr_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [gbr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [gbr_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [gbr_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [gbr_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // Shadow of the frame store and the registers.
  bit [23:0]         frame_copy [MAX_DIM * MAX_DIM];
  bit                pixel_written [MAX_DIM * MAX_DIM];
  logic [7:0]        reg_width = 8'd128;
  logic [7:0]        reg_height = 8'd128;
  longint unsigned   tap_weight [0:BLUR_RADIUS];
  blur_result_t      blur_expected [$];
  int                mismatch_count = 0;
  bit                gaps_on = 1'b1;

  gaussian_blur_rgb dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #TIMEOUT_NS;
    $display("Some tests failed");
    $finish;
  end

  // Effective frame size: zero acts as one, oversize acts as the maximum.
  function automatic int eff_size(logic [7:0] reg_val);
    if (reg_val == 8'd0) return 1;
    if (reg_val > MAX_DIM) return MAX_DIM;
    return int'(reg_val);
  endfunction

  function automatic int clamp_coord(int v, int lim);
    if (v < 0) return 0;
    if (v > lim - 1) return lim - 1;
    return v;
  endfunction

  // Expected blurred pixel from the shadow frame and the current registers.
  function automatic blur_result_t predict_blur(int x, int y);
    blur_result_t res;
    logic [63:0] acc_r, acc_g, acc_b, wt;
    int fw, fh, ix, iy, ay, ax;
    bit [23:0] p;
    fw = eff_size(reg_width);
    fh = eff_size(reg_height);
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    for (int ky = -BLUR_RADIUS; ky <= BLUR_RADIUS; ky++) begin
      iy = clamp_coord(y + ky, fh);
      ay = (ky < 0) ? -ky : ky;
      for (int kx = -BLUR_RADIUS; kx <= BLUR_RADIUS; kx++) begin
        ix = clamp_coord(x + kx, fw);
        ax = (kx < 0) ? -kx : kx;
        wt = tap_weight[ay] * tap_weight[ax];
        p = frame_copy[iy * MAX_DIM + ix];
        acc_r += wt * p[23:16];
        acc_g += wt * p[15:8];
        acc_b += wt * p[7:0];
      end
    end
    res.red = acc_r[39:32];
    res.green = acc_g[39:32];
    res.blue = acc_b[39:32];
    res.x = 7'(x);
    res.y = 7'(y);
    return res;
  endfunction

  // First pixel of the clamped window around (x,y) that was never loaded, if any.
  function automatic bit find_gap(int x, int y, output int gx, output int gy);
    int fw, fh, ix, iy;
    fw = eff_size(reg_width);
    fh = eff_size(reg_height);
    gx = 0;
    gy = 0;
    for (int ky = -BLUR_RADIUS; ky <= BLUR_RADIUS; ky++) begin
      iy = clamp_coord(y + ky, fh);
      for (int kx = -BLUR_RADIUS; kx <= BLUR_RADIUS; kx++) begin
        ix = clamp_coord(x + kx, fw);
        if (!pixel_written[iy * MAX_DIM + ix]) begin
          gx = ix;
          gy = iy;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Blur target coordinate: mostly near the edges, sometimes outside the frame.
  function automatic int pick_coord(int f);
    int v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom_range(0, 3);
      2: v = f - 1 - $urandom_range(0, (f < 4) ? f - 1 : 3);
      3: v = (f < MAX_DIM) ? $urandom_range(f, MAX_DIM - 1) : MAX_DIM - 1 - $urandom_range(0, 3);
      default: v = $urandom_range(0, (f <= 24) ? f - 1 : 3);
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_size();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(1, 16));
      1: return 8'($urandom_range(17, 128));
      2: return 8'($urandom_range(129, 255));
      default: return ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd128;
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Stop feeding, wait for every pending result and let trailing loads settle.
  task automatic drain_to_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write followed by a read-back, only while the block is idle.
  task automatic cfg_write(input logic [2:0] addr, input logic [7:0] value);
    logic [31:0] upper;
    drain_to_idle();
    upper = $urandom;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= {upper[31:8], value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    check_field((addr == ADDR_WIDTH) ? "frame_width" : "frame_height", value, cfg_prdata[7:0]);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_WIDTH) reg_width = value;
    else reg_height = value;
  endtask

  // Offer one input beat; on acceptance update the shadow or queue the expected pixel.
  task automatic send_beat(input bit blur, input int x, input int y, input logic [23:0] pix,
                           input bit typed, input logic [23:0] typed_pix);
    blur_result_t res;
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= blur ? gbr_pkg::ACT_COMPUTE : gbr_pkg::ACT_LOAD;
    in_tdata <= gbr_pkg::IN_DATA_W'({pix[7:0], pix[15:8], pix[23:16], 7'(y), 7'(x)});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (blur) begin
      if (typed) begin
        res.red = typed_pix[23:16];
        res.green = typed_pix[15:8];
        res.blue = typed_pix[7:0];
        res.x = 7'(x);
        res.y = 7'(y);
      end else begin
        res = predict_blur(x, y);
      end
      blur_expected.push_back(res);
    end else begin
      frame_copy[y * MAX_DIM + x] = pix;
      pixel_written[y * MAX_DIM + x] = 1'b1;
    end
  endtask

  // Result side stalls at random.
  always @(negedge clk) begin
    out_tready <= !gaps_on || ($urandom_range(0, 99) >= 14);
  end

  // Compare each result beat with the oldest expected pixel.
  always @(posedge clk) begin
    blur_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (blur_expected.size() == 0) begin
        $error("result beat with no blurred pixel pending");
        mismatch_count++;
      end else begin
        want = blur_expected.pop_front();
        check_field("out_red", want.red, out_tdata[7:0]);
        check_field("out_green", want.green, out_tdata[15:8]);
        check_field("out_blue", want.blue, out_tdata[23:16]);
        check_field("out_x", want.x, out_tdata[30:24]);
        check_field("out_y", want.y, out_tdata[37:31]);
      end
    end
  end

  initial begin
    longint unsigned kernel_sum, side_sum;
    logic [7:0] w_val, h_val;
    int tx, ty, gx, gy;
    bit have_target;

    // Normalized one-dimensional taps; the center absorbs the rounding.
    kernel_sum = KERNEL_RAW[0];
    for (int k = 1; k <= BLUR_RADIUS; k++) kernel_sum += 2 * KERNEL_RAW[k];
    side_sum = 0;
    for (int k = 1; k <= BLUR_RADIUS; k++) begin
      tap_weight[k] = (KERNEL_RAW[k] * 65536 + kernel_sum / 2) / kernel_sum;
      side_sum += 2 * tap_weight[k];
    end
    tap_weight[0] = 65536 - side_sum;
    tx = 0;
    ty = 0;
    have_target = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    foreach (directed_steps[i]) begin
      case (directed_steps[i].kind)
        STEP_CFG: cfg_write(directed_steps[i].addr, directed_steps[i].value);
        STEP_LOAD: send_beat(1'b0, directed_steps[i].x, directed_steps[i].y,
                             directed_steps[i].pix, 1'b0, 24'h0);
        default: send_beat(1'b1, directed_steps[i].x, directed_steps[i].y, 24'($urandom),
                           directed_steps[i].typed, directed_steps[i].exp_pix);
      endcase
    end

    // Random phases, each under its own frame size. Blur targets are held until
    // their window has been loaded, so most traffic builds toward valid blurs.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          w_val = 8'($urandom_range(1, 16));
          h_val = 8'($urandom_range(1, 16));
        end
        1: begin w_val = 8'd0;   h_val = 8'd0;   end
        2: begin w_val = 8'd1;   h_val = 8'd128; end
        3: begin w_val = 8'd128; h_val = 8'd1;   end
        4: begin w_val = 8'd255; h_val = 8'd255; end
        5: begin w_val = 8'd128; h_val = 8'd128; end
        default: begin
          w_val = pick_size();
          h_val = pick_size();
        end
      endcase
      cfg_write(ADDR_WIDTH, w_val);
      cfg_write(ADDR_HEIGHT, h_val);
      gaps_on = (phase != 5);
      have_target = 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) drain_to_idle();
        if ($urandom_range(0, 99) < 15) begin
          send_beat(1'b0, $urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                    24'($urandom), 1'b0, 24'h0);
        end else begin
          if (!have_target) begin
            tx = pick_coord(eff_size(reg_width));
            ty = pick_coord(eff_size(reg_height));
            have_target = 1'b1;
          end
          if (find_gap(tx, ty, gx, gy)) begin
            send_beat(1'b0, gx, gy, 24'($urandom), 1'b0, 24'h0);
          end else begin
            send_beat(1'b1, tx, ty, 24'($urandom), 1'b0, 24'h0);
            have_target = 1'b0;
          end
        end
      end
    end

    gaps_on = 1'b1;
    drain_to_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
